// ----- rtl/smac_pkg.sv -----
// Shared types, constants and a helper function for the stepper move-to-angle controller.
package smac_pkg;

	localparam int POS_W   = 20;
	localparam int ANGLE_W = 37;
	localparam int RES_W   = 16;
	localparam int PROD_W  = POS_W + RES_W + 1;
	localparam int CMP_W   = PROD_W + 1;

	localparam logic [RES_W-1:0] RES_RESET = 16'd11577;

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_TICK  = 2'd0;
	localparam mode_t MODE_MOVE  = 2'd1;
	localparam mode_t MODE_STOP  = 2'd2;
	localparam mode_t MODE_CLEAR = 2'd3;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_STEP_MODE = 1'b0;
	localparam cfg_idx_t CFG_STEP_RES  = 1'b1;

	// Outcome of one tick while a move is in progress.
	typedef struct packed {
		logic step_fwd;
		logic step_bwd;
		logic finish;
	} step_dec_t;

	// Wave drive energizes the coil at the phase; full drive adds the next coil.
	function automatic logic [3:0] coil_pattern(input logic [1:0] ph, input logic full);
		logic [3:0] one;
		logic [3:0] two;
		one = 4'b0001 << ph;
		two = 4'b0001 << (ph + 2'd1);
		coil_pattern = full ? (one | two) : one;
	endfunction

endpackage

// ----- rtl/stepper_move_to_angle_controller.sv -----
// Top level of the stepper move-to-angle controller.
//
// Input channel (in_valid/in_ready) carries a mode and a target angle in
// signed Q.16 degrees. Mode tick advances a move in progress by at most one
// step, move latches a target when idle, stop ends a move, and clear sets
// the position to zero. Every input transfer yields exactly one result
// transfer on the output channel (out_valid/out_ready) with the coil drive,
// the signed step count and the busy flag as they stand after the update.
// An accepted item sits in the input register until the result slot is
// free and is then processed into the result register. One item per cycle
// is sustained while out_ready stays high; the tick path is one 20x17 multiply
// of the step count by the resolution followed by a 38-bit add and compare.
// When the receiver stalls, the result register holds and the input
// register still takes one more item, after which in_ready drops.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) set step mode and
// resolution and should only be issued while no item is in flight.
// Reset clears all state but the input register payload: coils off, position zero,
// not busy, wave mode, and a resolution of 11577 (360/2038 degrees per step).
module stepper_move_to_angle_controller
	import smac_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                mode,
	input  logic signed [ANGLE_W-1:0] target_angle,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [3:0]                coils,
	output logic signed [POS_W-1:0]   position,
	output logic                      busy_res,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [RES_W-1:0]          cfg_wdata
);

	// Configuration registers.
	logic             step_mode_q;
	logic [RES_W-1:0] step_res_q;

	// Input register.
	logic                      valid_s1;
	mode_t                     mode_s1;
	logic signed [ANGLE_W-1:0] target_s1;

	// Controller state; it doubles as the result register.
	logic [1:0]                phase_q;
	logic signed [POS_W-1:0]   step_count_q;
	logic                      moving_q;
	logic signed [ANGLE_W-1:0] goal_q;
	logic [3:0]                coil_q;
	logic                      out_valid_q;

	logic      advance;
	logic      proc;
	step_dec_t dec;
	logic [1:0] phase_fwd;
	logic [1:0] phase_bwd;

	// The result slot is free when empty or being drained this cycle.
	assign advance  = !out_valid_q || out_ready;
	assign proc     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	assign phase_fwd = phase_q + 2'd1;
	assign phase_bwd = phase_q - 2'd1;

	smac_tick_decide u_decide (
		.step_count (step_count_q),
		.goal       (goal_q),
		.res        (step_res_q),
		.dec        (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_mode_q <= 1'b0;
			step_res_q  <= RES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEP_MODE: step_mode_q <= cfg_wdata[0];
				CFG_STEP_RES:  step_res_q  <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the input register needs no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1   <= mode;
			target_s1 <= target_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= 2'd0;
			step_count_q <= '0;
			moving_q     <= 1'b0;
			goal_q       <= '0;
			coil_q       <= 4'd0;
		end else if (proc) begin
			case (mode_s1)
				MODE_TICK: begin
					if (moving_q) begin
						if (dec.step_fwd) begin
							phase_q <= phase_fwd;
							coil_q  <= coil_pattern(phase_fwd, step_mode_q);
							if (step_count_q != POS_MAX) step_count_q <= step_count_q + POS_W'(1);
						end else if (dec.step_bwd) begin
							phase_q <= phase_bwd;
							coil_q  <= coil_pattern(phase_bwd, step_mode_q);
							if (step_count_q != POS_MIN) step_count_q <= step_count_q - POS_W'(1);
						end else begin
							moving_q <= 1'b0;
						end
					end
				end
				MODE_MOVE: begin
					if (!moving_q) begin
						moving_q <= 1'b1;
						goal_q   <= target_s1;
					end
				end
				MODE_STOP: begin
					moving_q <= 1'b0;
				end
				MODE_CLEAR: begin
					step_count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign coils     = coil_q;
	assign position  = step_count_q;
	assign busy_res  = moving_q;

	// Drive never energizes more than two coils.
	a_coil_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(coils) <= 2)
		else $error("more than two coils energized");

	// A stop always leaves the controller idle.
	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && mode_s1 == MODE_STOP) |=> !moving_q)
		else $error("stop did not clear busy");

	// Clearing the position gives a zero step count.
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && mode_s1 == MODE_CLEAR) |=> step_count_q == '0)
		else $error("clear did not zero the position");

	// A tick while idle changes neither phase nor position.
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && mode_s1 == MODE_TICK && !moving_q) |=>
		($stable(step_count_q) && $stable(phase_q)))
		else $error("idle tick moved the motor");

	// A stalled result must not be overwritten by a new item.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !proc)
		else $error("result overwritten while stalled");

endmodule

// ----- rtl/smac_tick_decide.sv -----
// Angle comparison that picks forward step, backward step or end of move.
module smac_tick_decide
	import smac_pkg::*;
(
	input  logic signed [POS_W-1:0]   step_count,
	input  logic signed [ANGLE_W-1:0] goal,
	input  logic [RES_W-1:0]          res,
	output step_dec_t                 dec
);

	logic signed [RES_W:0]     res_s;
	logic signed [PROD_W-1:0]  here_angle;
	logic signed [CMP_W-1:0]   here_x;
	logic signed [CMP_W-1:0]   res_x;
	logic signed [CMP_W-1:0]   up_angle;
	logic signed [CMP_W-1:0]   dn_angle;
	logic signed [CMP_W-1:0]   goal_x;

	assign res_s      = $signed({1'b0, res});
	assign here_angle = PROD_W'(step_count * res_s);
	assign here_x     = {here_angle[PROD_W-1], here_angle};
	assign res_x      = $signed({{(CMP_W-RES_W){1'b0}}, res});
	assign up_angle   = here_x + res_x;
	assign dn_angle   = here_x - res_x;
	assign goal_x     = {{(CMP_W-ANGLE_W){goal[ANGLE_W-1]}}, goal};

	// Step only when the goal lies beyond the angle one step away.
	always_comb begin
		dec = '0;
		if (goal_x > here_x) begin
			if (goal_x > up_angle) dec.step_fwd = 1'b1;
			else                   dec.finish   = 1'b1;
		end else begin
			if (goal_x < dn_angle) dec.step_bwd = 1'b1;
			else                   dec.finish   = 1'b1;
		end
	end

endmodule
